>>> rtl/hcmbd_pkg.sv
// Shared types and constants for the colour handheld memory bus decoder.
// Used by the front end, the request queue, the back end and the top level.
package hcmbd_pkg;

    localparam int ADDR_W  = 16;
    localparam int DATA_W  = 8;
    localparam int OFF_W   = 13;
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam int VRAM_DEPTH = 16384;
    localparam int WRAM_DEPTH = 32768;
    localparam int OAM_DEPTH  = 160;
    localparam int HRAM_DEPTH = 127;
    localparam int PAL_DEPTH  = 64;
    localparam int VRAM_AW    = $clog2(VRAM_DEPTH);
    localparam int WRAM_AW    = $clog2(WRAM_DEPTH);
    localparam int OAM_AW     = $clog2(OAM_DEPTH);
    localparam int HRAM_AW    = $clog2(HRAM_DEPTH);
    localparam int PAL_AW     = $clog2(PAL_DEPTH);

    localparam logic [ADDR_W-1:0] BOOT_LO_END  = 16'h0100;
    localparam logic [ADDR_W-1:0] BOOT_HI_BEG  = 16'h0200;
    localparam logic [ADDR_W-1:0] BOOT_HI_END  = 16'h0900;
    localparam logic [ADDR_W-1:0] VRAM_BEG     = 16'h8000;
    localparam logic [ADDR_W-1:0] CRAM_BEG     = 16'hA000;
    localparam logic [ADDR_W-1:0] WRAM0_BEG    = 16'hC000;
    localparam logic [ADDR_W-1:0] WRAMX_BEG    = 16'hD000;
    localparam logic [ADDR_W-1:0] ECHO_BEG     = 16'hE000;
    localparam logic [ADDR_W-1:0] OAM_BEG      = 16'hFE00;
    localparam logic [ADDR_W-1:0] UNUSABLE_BEG = 16'hFEA0;
    localparam logic [ADDR_W-1:0] IO_BEG       = 16'hFF00;
    localparam logic [ADDR_W-1:0] HRAM_BEG     = 16'hFF80;
    localparam logic [ADDR_W-1:0] IE_ADDR      = 16'hFFFF;

    localparam logic [7:0] REG_VBK  = 8'h4F;
    localparam logic [7:0] REG_BOOT = 8'h50;
    localparam logic [7:0] REG_BCPS = 8'h68;
    localparam logic [7:0] REG_BCPD = 8'h69;
    localparam logic [7:0] REG_OCPS = 8'h6A;
    localparam logic [7:0] REG_OCPD = 8'h6B;
    localparam logic [7:0] REG_SVBK = 8'h70;

    localparam logic [DATA_W-1:0] OPEN_BUS    = 8'hFF;
    localparam logic [DATA_W-1:0] VBK_FILL    = 8'hFE;
    localparam logic [DATA_W-1:0] VBK_RESET   = 8'hFE;
    localparam logic [DATA_W-1:0] PAL_IDX_MSK = 8'hBF;

    typedef enum logic [2:0] {
        RT_LOCAL = 3'd0,
        RT_BOOT  = 3'd1,
        RT_CROM  = 3'd2,
        RT_CRAM  = 3'd3,
        RT_IO    = 3'd4
    } route_t;

    typedef enum logic [4:0] {
        T_NONE, T_ROM, T_VRAM, T_CRAM, T_WRAM0, T_WRAMX, T_OAM, T_HRAM,
        T_IE, T_VBK, T_BOOT, T_BCPS, T_BCPD, T_OCPS, T_OCPD, T_SVBK, T_IO
    } target_t;

    typedef struct packed {
        logic              wr;
        target_t           target;
        logic [OFF_W-1:0]  offset;
        logic [DATA_W-1:0] data;
        logic              m3_block;
        logic              boot_window;
    } req_t;

    typedef struct packed {
        logic push;
        logic full;
    } q_ctl_t;

    function automatic logic [DATA_W-1:0] step_index(input logic [DATA_W-1:0] idx);
        logic [5:0] low;
        begin
            low = idx[5:0] + 6'd1;
            step_index = idx[7] ? {idx[7:6], low} : idx;
        end
    endfunction

endpackage

>>> rtl/hcmbd_front.sv
// Front end: accept bus requests, decode the address into a target class.
// Depends on hcmbd_pkg; feeds hcmbd_queue.
module hcmbd_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 s_tuser,   // [0] kind
    input  logic [31:0]          s_tdata,   // [15:0] address, [23:16] write_data,
                                            // [24] lcd_on, [26:25] video_mode
    input  logic                 q_full,
    output hcmbd_pkg::q_ctl_t    q_ctl,
    output hcmbd_pkg::req_t      q_req
);
    import hcmbd_pkg::*;

    logic              fr_valid_reg;
    req_t              fr_req_reg;
    req_t              req_next;
    logic [ADDR_W-1:0] a;
    logic              m3_block;
    logic              oam_block;
    logic              lcd_on;
    logic [1:0]        mode;
    logic              take;

    assign a         = s_tdata[15:0];
    assign lcd_on    = s_tdata[24];
    assign mode      = s_tdata[26:25];
    assign m3_block  = lcd_on && (mode == 2'd3);
    assign oam_block = lcd_on && (mode == 2'd2 || mode == 2'd3);

    always_comb begin
        req_next             = '0;
        req_next.wr          = s_tuser;
        req_next.offset      = a[OFF_W-1:0];
        req_next.data        = s_tdata[23:16];
        req_next.m3_block    = m3_block;
        req_next.boot_window = (a < BOOT_LO_END) || (a >= BOOT_HI_BEG && a < BOOT_HI_END);
        if (a < VRAM_BEG) begin
            req_next.target = T_ROM;
        end else if (a < CRAM_BEG) begin
            req_next.target = m3_block ? T_NONE : T_VRAM;
        end else if (a < WRAM0_BEG) begin
            req_next.target = T_CRAM;
        end else if (a < WRAMX_BEG) begin
            req_next.target = T_WRAM0;
        end else if (a < ECHO_BEG) begin
            req_next.target = T_WRAMX;
        end else if (a < OAM_BEG) begin
            req_next.target = T_NONE;
        end else if (a < UNUSABLE_BEG) begin
            req_next.target = oam_block ? T_NONE : T_OAM;
        end else if (a < IO_BEG) begin
            req_next.target = T_NONE;
        end else if (a < HRAM_BEG) begin
            unique case (a[7:0])
                REG_VBK:  req_next.target = T_VBK;
                REG_BOOT: req_next.target = T_BOOT;
                REG_BCPS: req_next.target = T_BCPS;
                REG_BCPD: req_next.target = T_BCPD;
                REG_OCPS: req_next.target = T_OCPS;
                REG_OCPD: req_next.target = T_OCPD;
                REG_SVBK: req_next.target = T_SVBK;
                default:  req_next.target = T_IO;
            endcase
        end else if (a < IE_ADDR) begin
            req_next.target = T_HRAM;
        end else begin
            req_next.target = T_IE;
        end
    end

    assign q_ctl.push = fr_valid_reg && !q_full;
    assign q_ctl.full = q_full;
    assign q_req      = fr_req_reg;
    assign s_tready   = !fr_valid_reg || !q_full;
    assign take       = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fr_valid_reg <= 1'b0;
        end else if (take) begin
            fr_valid_reg <= 1'b1;
        end else if (q_ctl.push) begin
            fr_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            fr_req_reg <= req_next;
        end
    end

endmodule

>>> rtl/hcmbd_queue.sv
// Two-entry request queue between the front end and the back end.
// Depends on hcmbd_pkg.
module hcmbd_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  hcmbd_pkg::q_ctl_t    in_ctl,
    input  hcmbd_pkg::req_t      in_req,
    output logic                 full,
    output logic                 out_valid,
    input  logic                 pop,
    output hcmbd_pkg::req_t      out_req
);
    import hcmbd_pkg::*;

    req_t               slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic               do_push;
    logic               do_pop;

    assign full      = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_req   = slot_reg[rd_ptr_reg];
    assign do_push   = in_ctl.push && !full;
    assign do_pop    = pop && out_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= in_req;
        end
    end

endmodule

>>> rtl/hcmbd_back.sv
// Back end: execute queued requests against the local stores and registers.
// Depends on hcmbd_pkg; holds video, work, sprite, high and palette RAMs.
module hcmbd_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  hcmbd_pkg::req_t      q_req,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [7:0] read_data
    output logic [2:0]           m_tuser    // [2:0] route
);
    import hcmbd_pkg::*;

    typedef enum logic [1:0] {
        S_EXEC = 2'b01,
        S_RESP = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    req_t               ent_reg;
    route_t             route_reg, route_next;
    logic [DATA_W-1:0]  regrd_reg, regrd_next;
    logic               m_valid_reg;
    logic [DATA_W-1:0]  m_data_reg, m_data_next;
    route_t             m_route_reg;

    logic               cap_reg;
    logic               boot_reg;
    logic               color_reg;
    logic [DATA_W-1:0]  vbk_reg;
    logic [DATA_W-1:0]  svbk_reg;
    logic [DATA_W-1:0]  bgidx_reg;
    logic [DATA_W-1:0]  objidx_reg;
    logic [DATA_W-1:0]  ie_reg;

    logic [DATA_W-1:0]  vram_mem [VRAM_DEPTH];
    logic [DATA_W-1:0]  wram_mem [WRAM_DEPTH];
    logic [DATA_W-1:0]  oam_mem  [OAM_DEPTH];
    logic [DATA_W-1:0]  hram_mem [HRAM_DEPTH];
    logic [DATA_W-1:0]  bgp_mem  [PAL_DEPTH];
    logic [DATA_W-1:0]  objp_mem [PAL_DEPTH];
    logic [DATA_W-1:0]  vram_q, wram_q, oam_q, hram_q, bgp_q, objp_q;

    logic               out_free;
    logic               wr;
    logic [2:0]         wbank;
    logic [VRAM_AW-1:0] vram_a;
    logic [WRAM_AW-1:0] wram_a;

    assign out_free = !m_valid_reg || m_tready;
    assign q_pop    = (state_reg == S_EXEC) && q_valid && out_free;
    assign wr       = q_pop && q_req.wr;

    always_comb begin
        wbank = svbk_reg[2:0];
        if (!color_reg || wbank == 3'd0) begin
            wbank = 3'd1;
        end
        if (q_req.target == T_WRAM0) begin
            wbank = 3'd0;
        end
    end

    assign vram_a = {color_reg & vbk_reg[0], q_req.offset[VRAM_AW-2:0]};
    assign wram_a = {wbank, q_req.offset[WRAM_AW-4:0]};

    always_ff @(posedge aclk) begin
        if (wr && q_req.target == T_VRAM) begin
            vram_mem[vram_a] <= q_req.data;
        end
        if (q_pop) begin
            vram_q <= vram_mem[vram_a];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr && (q_req.target == T_WRAM0 || q_req.target == T_WRAMX)) begin
            wram_mem[wram_a] <= q_req.data;
        end
        if (q_pop) begin
            wram_q <= wram_mem[wram_a];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr && q_req.target == T_OAM) begin
            oam_mem[q_req.offset[OAM_AW-1:0]] <= q_req.data;
        end
        if (q_pop) begin
            oam_q <= oam_mem[q_req.offset[OAM_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr && q_req.target == T_HRAM) begin
            hram_mem[q_req.offset[HRAM_AW-1:0]] <= q_req.data;
        end
        if (q_pop) begin
            hram_q <= hram_mem[q_req.offset[HRAM_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr && q_req.target == T_BCPD && !q_req.m3_block) begin
            bgp_mem[bgidx_reg[PAL_AW-1:0]] <= q_req.data;
        end
        if (q_pop) begin
            bgp_q <= bgp_mem[bgidx_reg[PAL_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr && q_req.target == T_OCPD && !q_req.m3_block) begin
            objp_mem[objidx_reg[PAL_AW-1:0]] <= q_req.data;
        end
        if (q_pop) begin
            objp_q <= objp_mem[objidx_reg[PAL_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg    <= 1'b1;
            boot_reg   <= 1'b1;
            color_reg  <= 1'b1;
            vbk_reg    <= VBK_RESET;
            svbk_reg   <= '0;
            bgidx_reg  <= '0;
            objidx_reg <= '0;
            ie_reg     <= '0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (wr) begin
                case (q_req.target)
                    T_VBK:  vbk_reg <= q_req.data | VBK_FILL;
                    T_BOOT: begin
                        if (boot_reg) begin
                            boot_reg  <= 1'b0;
                            color_reg <= cap_reg;
                            vbk_reg   <= OPEN_BUS;
                            svbk_reg  <= OPEN_BUS;
                        end
                    end
                    T_BCPS: bgidx_reg  <= q_req.data & PAL_IDX_MSK;
                    T_BCPD: bgidx_reg  <= step_index(bgidx_reg);
                    T_OCPS: objidx_reg <= q_req.data & PAL_IDX_MSK;
                    T_OCPD: objidx_reg <= step_index(objidx_reg);
                    T_SVBK: svbk_reg   <= q_req.data;
                    T_IE:   ie_reg     <= q_req.data;
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        unique case (q_req.target)
            T_ROM:   route_next = (!q_req.wr && boot_reg && q_req.boot_window) ? RT_BOOT : RT_CROM;
            T_CRAM:  route_next = RT_CRAM;
            T_IO:    route_next = RT_IO;
            default: route_next = RT_LOCAL;
        endcase
        unique case (q_req.target)
            T_VBK:   regrd_next = vbk_reg;
            T_BCPS:  regrd_next = bgidx_reg;
            T_OCPS:  regrd_next = objidx_reg;
            T_SVBK:  regrd_next = svbk_reg;
            T_IE:    regrd_next = ie_reg;
            default: regrd_next = OPEN_BUS;
        endcase
    end

    always_comb begin
        unique case (ent_reg.target) inside
            T_VRAM:                      m_data_next = vram_q;
            T_WRAM0, T_WRAMX:            m_data_next = wram_q;
            T_OAM:                       m_data_next = oam_q;
            T_HRAM:                      m_data_next = hram_q;
            T_BCPD:                      m_data_next = ent_reg.m3_block ? OPEN_BUS : bgp_q;
            T_OCPD:                      m_data_next = ent_reg.m3_block ? OPEN_BUS : objp_q;
            T_VBK, T_BCPS, T_OCPS, T_SVBK, T_IE: m_data_next = regrd_reg;
            default:                     m_data_next = OPEN_BUS;
        endcase
        if (ent_reg.wr) begin
            m_data_next = OPEN_BUS;
        end
    end

    always_comb begin
        unique case (state_reg)
            S_EXEC:  state_next = q_pop ? S_RESP : S_EXEC;
            S_RESP:  state_next = S_EXEC;
            default: state_next = S_EXEC;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_EXEC;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_RESP) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            ent_reg   <= q_req;
            route_reg <= route_next;
            regrd_reg <= regrd_next;
        end
        if (state_reg == S_RESP) begin
            m_data_reg  <= m_data_next;
            m_route_reg <= route_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_route_reg;

    a_pop_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> out_free)
        else $error("request taken while result slot busy");

    a_pop_then_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> (state_reg == S_RESP))
        else $error("response phase missing after pop");

    a_resp_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RESP) |=> m_valid_reg)
        else $error("result not presented after response phase");

    a_boot_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        !boot_reg |=> !boot_reg)
        else $error("boot mode re-entered");

    a_regs_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (vbk_reg[7:1] == 7'h7F) && !bgidx_reg[6] && !objidx_reg[6])
        else $error("fixed register bits disturbed");

endmodule

>>> rtl/handheld_color_memory_bus_decoder.sv
// Colour handheld memory bus decoder: one CPU access in, one result out.
// Path: input accept, front-end register, queue, back-end issue and registered
// memory read, result register; the back end takes no new access until its
// response phase ends; a 2-entry queue parts the front end from the back.
// Reset: synchronous active-low aresetn resets control and mapped registers;
// RAM and data-path contents are not cleared and have no clearing pass.
module handheld_color_memory_bus_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,   // cartridge_color_capable
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tuser,       // [0] kind
    input  logic [31:0] s_tdata,       // [15:0] address, [23:16] write_data,
                                       // [24] lcd_on, [26:25] video_mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,       // [7:0] read_data
    output logic [2:0]  m_tuser        // [2:0] route
);
    import hcmbd_pkg::*;

    q_ctl_t q_ctl;
    req_t   fr_req;
    req_t   hd_req;
    logic   q_full;
    logic   q_valid;
    logic   q_pop;

    hcmbd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_ctl    (q_ctl),
        .q_req    (fr_req)
    );

    hcmbd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_ctl    (q_ctl),
        .in_req    (fr_req),
        .full      (q_full),
        .out_valid (q_valid),
        .pop       (q_pop),
        .out_req   (hd_req)
    );

    hcmbd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_req       (hd_req),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

>>> sim/handheld_color_memory_bus_decoder_test.sv
// Self-checking bench for the colour handheld memory bus decoder: directed and
// random bus accesses against a behavioural model of the decode and stores.
// Depends on rtl/hcmbd_pkg.sv and rtl/handheld_color_memory_bus_decoder.sv.
module handheld_color_memory_bus_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hcmbd_pkg::*;

    localparam bit ACC_RD = 1'b0;
    localparam bit ACC_WR = 1'b1;

    localparam logic [1:0] VM_HBLANK = 2'd0;
    localparam logic [1:0] VM_VBLANK = 2'd1;
    localparam logic [1:0] VM_OAM    = 2'd2;
    localparam logic [1:0] VM_DRAW   = 2'd3;

    localparam logic [15:0] VBK_ADDR  = IO_BEG + 16'(REG_VBK);
    localparam logic [15:0] BOOT_ADDR = IO_BEG + 16'(REG_BOOT);
    localparam logic [15:0] BCPS_ADDR = IO_BEG + 16'(REG_BCPS);
    localparam logic [15:0] BCPD_ADDR = IO_BEG + 16'(REG_BCPD);
    localparam logic [15:0] OCPS_ADDR = IO_BEG + 16'(REG_OCPS);
    localparam logic [15:0] OCPD_ADDR = IO_BEG + 16'(REG_OCPD);
    localparam logic [15:0] SVBK_ADDR = IO_BEG + 16'(REG_SVBK);

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 250;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic        wr;
        logic [15:0] addr;
        logic [7:0]  wdata;
        logic        lcd;
        logic [1:0]  vmode;
    } bus_access_t;

    typedef struct packed {
        logic [7:0] rdata;
        route_t     route;
    } bus_reply_t;

    typedef struct packed {
        bus_access_t acc;
        bus_reply_t  reply;
    } queued_access_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic        s_tuser = 1'b0;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [2:0]  m_tuser;

    handheld_color_memory_bus_decoder u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // model state
    logic [7:0] vid_mem  [VRAM_DEPTH];
    bit         vid_ok   [VRAM_DEPTH];
    logic [7:0] work_mem [WRAM_DEPTH];
    bit         work_ok  [WRAM_DEPTH];
    logic [7:0] oam_mem  [OAM_DEPTH];
    bit         oam_ok   [OAM_DEPTH];
    logic [7:0] hram_mem [HRAM_DEPTH];
    bit         hram_ok  [HRAM_DEPTH];
    logic [7:0] pal_mem  [2][PAL_DEPTH];
    bit         pal_ok   [2][PAL_DEPTH];
    logic [7:0] pal_ptr  [2] = '{8'h00, 8'h00};
    logic [7:0] ie_reg   = 8'h00;
    logic [7:0] vbk_reg  = VBK_RESET;
    logic [7:0] svbk_reg = 8'h00;
    bit         boot_on    = 1'b1;
    bit         colour_on  = 1'b1;
    bit         colour_cap = 1'b1;
    bit         boot_guard = 1'b0;

    queued_access_t access_q[$];
    bus_reply_t     read_back_q[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int cycle_count    = 0;
    int fault_count    = 0;
    int reply_count    = 0;
    int read_count     = 0;
    int write_count    = 0;
    int cfg_writes     = 0;

    function automatic int vram_slot(input logic [15:0] addr);
        return {colour_on & vbk_reg[0], addr[12:0]};
    endfunction

    function automatic int wram_slot(input logic [15:0] addr);
        logic [2:0] bank;
        bank = 3'd0;
        if (addr >= WRAMX_BEG) begin
            bank = svbk_reg[2:0];
            if (!colour_on || bank == 3'd0)
                bank = 3'd1;
        end
        return {bank, addr[11:0]};
    endfunction

    function automatic bit never_written(input logic [15:0] addr);
        if (addr >= VRAM_BEG && addr < CRAM_BEG)
            return !vid_ok[vram_slot(addr)];
        if (addr >= WRAM0_BEG && addr < ECHO_BEG)
            return !work_ok[wram_slot(addr)];
        if (addr >= OAM_BEG && addr < UNUSABLE_BEG)
            return !oam_ok[addr - OAM_BEG];
        if (addr >= HRAM_BEG && addr < IE_ADDR)
            return !hram_ok[addr - HRAM_BEG];
        if (addr == BCPD_ADDR)
            return !pal_ok[0][pal_ptr[0][5:0]];
        if (addr == OCPD_ADDR)
            return !pal_ok[1][pal_ptr[1][5:0]];
        return 1'b0;
    endfunction

    function automatic bus_reply_t decode_access(input bus_access_t a);
        bus_reply_t r;
        bit draw_lock;
        bit scan_lock;
        bit sel;
        int idx;
        r.rdata = OPEN_BUS;
        r.route = RT_LOCAL;
        draw_lock = a.lcd && a.vmode == VM_DRAW;
        scan_lock = a.lcd && (a.vmode == VM_OAM || a.vmode == VM_DRAW);
        if (a.addr < VRAM_BEG) begin
            if (!a.wr && boot_on && (a.addr < BOOT_LO_END ||
                    (a.addr >= BOOT_HI_BEG && a.addr < BOOT_HI_END)))
                r.route = RT_BOOT;
            else
                r.route = RT_CROM;
        end else if (a.addr < CRAM_BEG) begin
            idx = vram_slot(a.addr);
            if (!draw_lock) begin
                if (a.wr) begin
                    vid_mem[idx] = a.wdata;
                    vid_ok[idx] = 1'b1;
                end else begin
                    r.rdata = vid_mem[idx];
                end
            end
        end else if (a.addr < WRAM0_BEG) begin
            r.route = RT_CRAM;
        end else if (a.addr < ECHO_BEG) begin
            idx = wram_slot(a.addr);
            if (a.wr) begin
                work_mem[idx] = a.wdata;
                work_ok[idx] = 1'b1;
            end else begin
                r.rdata = work_mem[idx];
            end
        end else if (a.addr >= OAM_BEG && a.addr < UNUSABLE_BEG) begin
            idx = a.addr - OAM_BEG;
            if (!scan_lock) begin
                if (a.wr) begin
                    oam_mem[idx] = a.wdata;
                    oam_ok[idx] = 1'b1;
                end else begin
                    r.rdata = oam_mem[idx];
                end
            end
        end else if (a.addr >= IO_BEG && a.addr < HRAM_BEG) begin
            case (a.addr[7:0]) inside
                REG_VBK: begin
                    if (a.wr) vbk_reg = a.wdata | VBK_FILL;
                    else r.rdata = vbk_reg;
                end
                REG_BOOT: begin
                    if (a.wr && boot_on) begin
                        boot_on = 1'b0;
                        colour_on = colour_cap;
                        vbk_reg = 8'hFF;
                        svbk_reg = 8'hFF;
                    end
                end
                REG_BCPS, REG_OCPS: begin
                    sel = (a.addr[7:0] == REG_OCPS);
                    if (a.wr) pal_ptr[sel] = a.wdata & PAL_IDX_MSK;
                    else r.rdata = pal_ptr[sel];
                end
                REG_BCPD, REG_OCPD: begin
                    sel = (a.addr[7:0] == REG_OCPD);
                    if (a.wr) begin
                        if (!draw_lock) begin
                            pal_mem[sel][pal_ptr[sel][5:0]] = a.wdata;
                            pal_ok[sel][pal_ptr[sel][5:0]] = 1'b1;
                        end
                        if (pal_ptr[sel][7])
                            pal_ptr[sel][5:0] = pal_ptr[sel][5:0] + 6'd1;
                    end else if (!draw_lock) begin
                        r.rdata = pal_mem[sel][pal_ptr[sel][5:0]];
                    end
                end
                REG_SVBK: begin
                    if (a.wr) svbk_reg = a.wdata;
                    else r.rdata = svbk_reg;
                end
                default: r.route = RT_IO;
            endcase
        end else if (a.addr >= HRAM_BEG && a.addr < IE_ADDR) begin
            idx = a.addr - HRAM_BEG;
            if (a.wr) begin
                hram_mem[idx] = a.wdata;
                hram_ok[idx] = 1'b1;
            end else begin
                r.rdata = hram_mem[idx];
            end
        end else if (a.addr == IE_ADDR) begin
            if (a.wr) ie_reg = a.wdata;
            else r.rdata = ie_reg;
        end
        if (a.wr)
            r.rdata = OPEN_BUS;
        return r;
    endfunction

    task automatic queue_access(input bit wr, input logic [15:0] addr,
                                input logic [7:0] data, input bit lcd,
                                input logic [1:0] vmode);
        queued_access_t p;
        p.acc.wr = wr;
        p.acc.addr = addr;
        p.acc.wdata = data;
        p.acc.lcd = lcd;
        p.acc.vmode = vmode;
        if (!p.acc.wr && never_written(addr))
            p.acc.wr = ACC_WR;
        if (boot_guard && p.acc.wr && addr == BOOT_ADDR)
            p.acc.wr = ACC_RD;
        if (p.acc.wr) write_count++;
        else read_count++;
        p.reply = decode_access(p.acc);
        access_q.push_back(p);
    endtask

    // keep most accesses on a few small windows so that reads find written data
    function automatic logic [15:0] region_offset(input logic [15:0] top);
        logic [15:0] base;
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom_range(0, top));
        base = ((top >> 1) & 16'hFFF0) * 16'($urandom_range(0, 2));
        return base + 16'($urandom_range(0, 7));
    endfunction

    function automatic logic [15:0] random_address();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            if ($urandom_range(0, 1) != 0)
                return 16'($urandom_range(0, 16'h0A00));
            return 16'($urandom_range(0, 16'h7FFF));
        end
        if (pick < 28)
            return VRAM_BEG + region_offset(16'h1FFF);
        if (pick < 31)
            return 16'($urandom_range(CRAM_BEG, WRAM0_BEG - 1));
        if (pick < 45)
            return ($urandom_range(0, 1) ? WRAMX_BEG : WRAM0_BEG) + region_offset(16'h0FFF);
        if (pick < 48)
            return 16'($urandom_range(ECHO_BEG, OAM_BEG - 1));
        if (pick < 55)
            return 16'($urandom_range(OAM_BEG, UNUSABLE_BEG - 1));
        if (pick < 58)
            return 16'($urandom_range(UNUSABLE_BEG, IO_BEG - 1));
        if (pick < 78) begin
            case ($urandom_range(0, 9))
                0: return VBK_ADDR;
                1: return BOOT_ADDR;
                2: return BCPS_ADDR;
                3: return BCPD_ADDR;
                4: return OCPS_ADDR;
                5: return OCPD_ADDR;
                6: return SVBK_ADDR;
                default: return 16'($urandom_range(IO_BEG, HRAM_BEG - 1));
            endcase
        end
        if (pick < 90)
            return 16'($urandom_range(HRAM_BEG, IE_ADDR - 1));
        if (pick < 94)
            return IE_ADDR;
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    task automatic flag_fault(input string msg);
        fault_count++;
        if (fault_count <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    task automatic set_colour_capable(input bit value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        colour_cap = value;
        cfg_writes++;
    endtask

    task automatic wait_drain();
        while (access_q.size() != 0 || read_back_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic run_phase(input int send_pct, input int stall_pct, input int count,
                             input bit squeeze);
        @(negedge aclk);
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
        if (squeeze)
            hold_req++;
        repeat (count)
            queue_access(1'($urandom_range(0, 1)), random_address(),
                         8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         2'($urandom_range(0, 3)));
        wait_drain();
    endtask

    initial begin
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d requests pending",
                     cycle_count, access_q.size() + read_back_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // request driver: hold the offered request until it is taken
    always @(posedge aclk) begin
        logic offer;
        offer = 1'b0;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                read_back_q.push_back(access_q[0].reply);
                void'(access_q.pop_front());
            end
            offer = s_tvalid && !s_tready;
            if (!offer && access_q.size() != 0)
                offer = $urandom_range(0, 99) >= send_idle_pct;
        end
        s_tvalid <= offer;
        if (offer) begin
            s_tuser <= access_q[0].acc.wr;
            s_tdata <= {5'd0, access_q[0].acc.vmode, access_q[0].acc.lcd,
                        access_q[0].acc.wdata, access_q[0].acc.addr};
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= $urandom_range(0, 99) >= recv_stall_pct;
        end
    end

    always @(posedge aclk) begin
        bus_reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            reply_count <= reply_count + 1;
            if (read_back_q.size() == 0) begin
                flag_fault($sformatf("reply %0d with no request outstanding: data %02h route %0d",
                                     reply_count, m_tdata, m_tuser));
            end else begin
                want = read_back_q.pop_front();
                if (m_tdata !== want.rdata)
                    flag_fault($sformatf("reply %0d read_data: expected %02h, got %02h",
                                         reply_count, want.rdata, m_tdata));
                if (m_tuser !== want.route)
                    flag_fault($sformatf("reply %0d route: expected %0d, got %0d",
                                         reply_count, want.route, m_tuser));
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        set_colour_capable(1'b1);

        @(negedge aclk);
        boot_guard = 1'b1;
        queue_access(ACC_RD, 16'h0000, 8'h00, 1'b0, VM_HBLANK);
        queue_access(ACC_RD, 16'h0100, 8'h00, 1'b0, VM_HBLANK);
        queue_access(ACC_RD, 16'h0200, 8'h00, 1'b0, VM_HBLANK);
        queue_access(ACC_RD, 16'h08FF, 8'h00, 1'b0, VM_HBLANK);
        queue_access(ACC_RD, 16'h0900, 8'h00, 1'b0, VM_HBLANK);
        queue_access(ACC_RD, 16'h7FFF, 8'h00, 1'b1, VM_DRAW);
        queue_access(ACC_WR, 16'h0000, 8'hFF, 1'b0, VM_HBLANK);
        queue_access(ACC_WR, 16'h8000, 8'h00, 1'b1, VM_OAM);
        queue_access(ACC_WR, VBK_ADDR, 8'h01, 1'b0, VM_HBLANK);
        queue_access(ACC_WR, 16'h9FFF, 8'hA5, 1'b0, VM_DRAW);
        queue_access(ACC_RD, 16'h9FFF, 8'h00, 1'b1, VM_DRAW);
        queue_access(ACC_RD, 16'h9FFF, 8'h00, 1'b1, VM_VBLANK);
        queue_access(ACC_WR, SVBK_ADDR, 8'h08, 1'b0, VM_HBLANK);
        queue_access(ACC_WR, 16'hDFFF, 8'h5A, 1'b0, VM_HBLANK);
        queue_access(ACC_RD, 16'hDFFF, 8'h00, 1'b0, VM_HBLANK);
        queue_access(ACC_WR, 16'hFE9F, 8'h3C, 1'b1, VM_OAM);
        queue_access(ACC_WR, BCPS_ADDR, 8'hFF, 1'b0, VM_HBLANK);
        queue_access(ACC_WR, BCPD_ADDR, 8'h77, 1'b1, VM_DRAW);
        queue_access(ACC_RD, BCPS_ADDR, 8'h00, 1'b0, VM_HBLANK);
        queue_access(ACC_WR, OCPD_ADDR, 8'h11, 1'b0, VM_DRAW);
        queue_access(ACC_RD, OCPD_ADDR, 8'h00, 1'b0, VM_HBLANK);
        queue_access(ACC_WR, IE_ADDR, 8'h1F, 1'b0, VM_HBLANK);
        queue_access(ACC_RD, IE_ADDR, 8'h00, 1'b0, VM_HBLANK);
        queue_access(ACC_RD, 16'hFEA0, 8'h00, 1'b0, VM_HBLANK);
        queue_access(ACC_RD, IO_BEG, 8'h00, 1'b0, VM_HBLANK);
        run_phase(0, 0, 275, 1'b0);
        boot_guard = 1'b0;

        // leave boot mode with colour disabled, then keep rewriting the setting
        set_colour_capable(1'b0);
        @(negedge aclk);
        queue_access(ACC_WR, BOOT_ADDR, 8'h01, 1'b0, VM_HBLANK);
        run_phase(48, 0, 300, 1'b0);
        set_colour_capable(1'b1);
        run_phase(0, 48, 300, 1'b1);
        set_colour_capable(1'b0);
        run_phase(13, 13, 400, 1'b0);

        $display("Ran %0d bus accesses (%0d reads, %0d writes), %0d replies checked",
                 read_count + write_count, read_count, write_count, reply_count);
        $display("Covered boot exit, %0d setting writes, four idle/stall mixes and a long hold",
                 cfg_writes);
        if (fault_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
